FILE: design/vbtk_pkg.sv
// shared constants for the vertex bone weight top keeper
package vbtk_pkg;

  localparam int unsigned VERTEX_COUNT_DEF = 4096;
  localparam int unsigned SLOTS_DEF        = 4;
  localparam int unsigned BONE_ID_BITS_DEF = 8;

  localparam int unsigned VIDX_W     = 12;
  localparam int unsigned BONE_IN_W  = 8;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned SLOT_OUT_W = 2;
  localparam int unsigned REPORTED   = 4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_EMPTY = '0;

endpackage

FILE: design/vbtk_if.sv
// input and result channel interfaces
interface vbtk_in_if;
  import vbtk_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VIDX_W-1:0]    vertex_index;
  logic [BONE_IN_W-1:0] bone_id;
  logic [WEIGHT_W-1:0]  weight;

  modport source (output valid, vertex_index, bone_id, weight, input ready);
  modport sink   (input valid, vertex_index, bone_id, weight, output ready);
endinterface

interface vbtk_out_if;
  import vbtk_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  stored;
  logic [SLOT_OUT_W-1:0] slot_written;
  logic [BONE_IN_W-1:0]  id_slot0;
  logic [BONE_IN_W-1:0]  id_slot1;
  logic [BONE_IN_W-1:0]  id_slot2;
  logic [BONE_IN_W-1:0]  id_slot3;
  logic [WEIGHT_W-1:0]   weight_slot0;
  logic [WEIGHT_W-1:0]   weight_slot1;
  logic [WEIGHT_W-1:0]   weight_slot2;
  logic [WEIGHT_W-1:0]   weight_slot3;

  modport source (output valid, stored, slot_written, id_slot0, id_slot1, id_slot2, id_slot3,
                  weight_slot0, weight_slot1, weight_slot2, weight_slot3, input ready);
  modport sink   (input valid, stored, slot_written, id_slot0, id_slot1, id_slot2, id_slot3,
                  weight_slot0, weight_slot1, weight_slot2, weight_slot3, output ready);
endinterface

FILE: design/vbtk_ram.sv
// generic simple dual port ram with registered read
module vbtk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/vertex_bone_weight_top_keeper_top.sv
// per-vertex top bone influence keeper, top level
// result: registered from the calc state after the ram read, and held back while an older result waits
// items: a new input is taken only in the idle state, once the read and write-back of the last one are done
// reset: a clearing pass writes every vertex entry to zero, one per cycle,
//   after rst_n rises; no input is taken until it ends
// result register frees the input side while a result waits
module vertex_bone_weight_top_keeper_top #(
  parameter int unsigned VERTEX_COUNT     = vbtk_pkg::VERTEX_COUNT_DEF,
  parameter int unsigned SLOTS_PER_VERTEX = vbtk_pkg::SLOTS_DEF,
  parameter int unsigned BONE_ID_BITS     = vbtk_pkg::BONE_ID_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  vbtk_in_if.sink    in_chan,
  vbtk_out_if.source out_chan
);
  import vbtk_pkg::*;

  localparam int unsigned ADDR_W = VERTEX_COUNT > 1 ? $clog2(VERTEX_COUNT) : 1;
  localparam int unsigned SLOT_W = SLOTS_PER_VERTEX > 1 ? $clog2(SLOTS_PER_VERTEX) : 1;
  localparam int unsigned IDS_W  = SLOTS_PER_VERTEX * BONE_ID_BITS;
  localparam int unsigned WORD_W = SLOTS_PER_VERTEX * (BONE_ID_BITS + WEIGHT_W);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [ADDR_W-1:0]       clr_addr_r, clr_addr_nxt;
  logic [ADDR_W-1:0]       addr_r;
  logic                    in_range_r;
  logic [BONE_ID_BITS-1:0] id_r;
  logic [WEIGHT_W-1:0]     w_r;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_stored_r;
  logic [SLOT_OUT_W-1:0]   out_slot_r;
  logic [BONE_IN_W-1:0]    out_id_r [REPORTED];
  logic [WEIGHT_W-1:0]     out_w_r  [REPORTED];

  logic                    in_xfer, calc_go;
  logic                    ram_wr_en;
  logic [ADDR_W-1:0]       ram_wr_addr;
  logic [WORD_W-1:0]       ram_wr_data, ram_rd_data, new_word;

  logic [BONE_ID_BITS-1:0] ids    [SLOTS_PER_VERTEX];
  logic [WEIGHT_W-1:0]     ws     [SLOTS_PER_VERTEX];
  logic [BONE_ID_BITS-1:0] ids_up [SLOTS_PER_VERTEX];
  logic [WEIGHT_W-1:0]     ws_up  [SLOTS_PER_VERTEX];
  logic                    found_empty, do_store;
  logic [SLOT_W-1:0]       empty_slot, min_slot, sel_slot;
  logic [WEIGHT_W-1:0]     min_w;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign calc_go       = (state_r == ST_CALC) && (!out_valid_r || out_chan.ready);

  // slot scan and update
  always_comb begin
    found_empty = 1'b0;
    empty_slot  = '0;
    min_slot    = '0;
    for (int i = 0; i < SLOTS_PER_VERTEX; i++) begin
      ids[i] = ram_rd_data[i*BONE_ID_BITS +: BONE_ID_BITS];
      ws[i]  = ram_rd_data[IDS_W + i*WEIGHT_W +: WEIGHT_W];
    end
    min_w = ws[0];
    for (int i = 0; i < SLOTS_PER_VERTEX; i++) begin
      if (!found_empty) begin
        if (ws[i] == WEIGHT_EMPTY) begin
          found_empty = 1'b1;
          empty_slot  = SLOT_W'(i);
        end else if (ws[i] < min_w) begin
          min_w    = ws[i];
          min_slot = SLOT_W'(i);
        end
      end
    end
    do_store = in_range_r && (found_empty || (w_r > min_w));
    sel_slot = found_empty ? empty_slot : min_slot;
    for (int i = 0; i < SLOTS_PER_VERTEX; i++) begin
      ids_up[i] = ids[i];
      ws_up[i]  = ws[i];
      if (do_store && (sel_slot == SLOT_W'(i))) begin
        ids_up[i] = id_r;
        ws_up[i]  = w_r;
      end
      new_word[i*BONE_ID_BITS +: BONE_ID_BITS] = ids_up[i];
      new_word[IDS_W + i*WEIGHT_W +: WEIGHT_W] = ws_up[i];
    end
  end

  // write port shared by the clearing pass and the write-back
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr_r;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = calc_go && do_store;
      ram_wr_addr = addr_r;
      ram_wr_data = new_word;
    end
  end

  vbtk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VERTEX_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_xfer),
    .rd_addr (ADDR_W'(in_chan.vertex_index)),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(VERTEX_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (calc_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (calc_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      addr_r     <= ADDR_W'(in_chan.vertex_index);
      in_range_r <= (32'(in_chan.vertex_index) < VERTEX_COUNT);
      id_r       <= BONE_ID_BITS'(in_chan.bone_id);
      w_r        <= in_chan.weight;
    end
    if (calc_go) begin
      out_stored_r <= do_store;
      out_slot_r   <= do_store ? SLOT_OUT_W'(sel_slot) : '0;
      for (int i = 0; i < REPORTED; i++) begin
        out_id_r[i] <= '0;
        out_w_r[i]  <= '0;
        if (i < SLOTS_PER_VERTEX && in_range_r) begin
          out_id_r[i] <= BONE_IN_W'(ids_up[i]);
          out_w_r[i]  <= ws_up[i];
        end
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.stored       = out_stored_r;
  assign out_chan.slot_written = out_slot_r;
  assign out_chan.id_slot0     = out_id_r[0];
  assign out_chan.id_slot1     = out_id_r[1];
  assign out_chan.id_slot2     = out_id_r[2];
  assign out_chan.id_slot3     = out_id_r[3];
  assign out_chan.weight_slot0 = out_w_r[0];
  assign out_chan.weight_slot1 = out_w_r[1];
  assign out_chan.weight_slot2 = out_w_r[2];
  assign out_chan.weight_slot3 = out_w_r[3];

  a_xfer_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_CALC))
    else $error("input transfer did not start an update");

  a_calc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    calc_go |=> out_valid_r)
    else $error("finished update left no result");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_wr_en)
    else $error("table written while idle");

  a_range_store: assert property (@(posedge clk) disable iff (!rst_n)
    (calc_go && !in_range_r) |=> (out_valid_r && !out_stored_r))
    else $error("out of range vertex reported as stored");

endmodule
